[sv/frq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frq_pkg: shared types and constants for the frame ring queue
// Holds the item structs, opcodes, status codes, the controller state type
// and the default sizes that the top level hands down.
// ----------------------------------------------------------------------------
package frq_pkg;

  localparam int QUEUE_FRAMES_DEF = 8;
  localparam int FRAME_BYTES_DEF  = 64;

  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 7;
  localparam int HELD_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
    logic              carries_byte;
    logic              frame_end;
  } frq_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_present;
    logic                run_last;
    logic [STATUS_W-1:0] status;
    logic [HELD_W-1:0]   frames_held;
    logic                not_empty;
    logic                is_full;
  } frq_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } frq_state_t;

endpackage

[sv/frq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frq_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module frq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/frame_ring_queue_overwrite_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_ring_queue_overwrite_unit: ring of byte frames, oldest overwritten
// Pushes stream bytes into the head slot and commit on frame_end; pulls
// deliver the tail frame byte by byte, or report empty or over-limit.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   in_*      input      in_valid / in_stall     frq_in_t  (opcode, byte, marks)
//   out_*     output     out_valid / out_stall   frq_out_t (byte, last, status, flags)
//   cfg_*     input      cfg_wr_en               frame_limit (7 bits)
//
// A push is taken in ST_IDLE, and a new item can follow it unless the output
// stalls. An empty pull is also answered in ST_IDLE. A pull of a stored frame
// reads its descriptor, checks it in ST_CHECK, then in ST_EMIT reads the first
// byte from the byte memory and loads one byte per cycle into the output
// register while the output does not stall. A rejected or empty frame is
// answered from ST_CHECK. Both memories have registered read data.
// Reset clears pointers, push counters, frame_limit (to 64) and the output
// valid flag; the memories are not cleared. A stall on the output holds the
// output register and the byte read pipeline; the input stalls meanwhile.
// ----------------------------------------------------------------------------
module frame_ring_queue_overwrite_unit #(
  parameter int QUEUE_FRAMES = frq_pkg::QUEUE_FRAMES_DEF,
  parameter int FRAME_BYTES  = frq_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  frq_pkg::frq_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output frq_pkg::frq_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [frq_pkg::LIMIT_W-1:0]   cfg_wr_data
);

  import frq_pkg::*;

  localparam int SLOT_W = $clog2(QUEUE_FRAMES);
  localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int DEPTH  = QUEUE_FRAMES * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DESC_W = CNT_W + 1;
  localparam int HW     = (SLOT_W + 1 > HELD_W) ? SLOT_W + 1 : HELD_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_FRAMES - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(FRAME_BYTES);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    r = (s == LAST_SLOT) ? '0 : s + 1'b1;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [IDX_W-1:0] i);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(s) * ADDR_W'(FRAME_BYTES) + ADDR_W'(i);
    return a;
  endfunction

  // control state
  frq_state_t          state_r, state_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [SLOT_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]    push_cnt_r, push_cnt_nxt;
  logic                push_over_r, push_over_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  logic                out_valid_r, out_valid_nxt;
  frq_out_t            out_data_r, out_data_nxt;

  // pull stream state
  logic [SLOT_W-1:0]   pull_slot_r, pull_slot_nxt;
  logic [CNT_W-1:0]    pull_len_r, pull_len_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                rd_last_r, rd_last_nxt;

  // memory ports
  logic                byte_we, byte_re;
  logic [ADDR_W-1:0]   byte_waddr, byte_raddr;
  logic [BYTE_W-1:0]   byte_rdata;
  logic                desc_we, desc_re;
  logic [SLOT_W-1:0]   desc_waddr;
  logic [DESC_W-1:0]   desc_wdata, desc_rdata;

  // result loading
  logic                out_free, accept;
  logic                ld_en, ld_present, ld_last;
  logic [BYTE_W-1:0]   ld_byte;
  logic [STATUS_W-1:0] ld_status;
  logic [HW-1:0]       held_diff, held_val;

  // pull decision on the descriptor just read
  logic [CNT_W-1:0]    d_len;
  logic                d_reject;
  logic                issue;

  // push bookkeeping
  logic [CNT_W-1:0]    cnt_upd;
  logic                over_upd;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign d_len    = desc_rdata[CNT_W-1:0];
  assign d_reject = desc_rdata[CNT_W] || (LIMIT_W'(d_len) > limit_r);
  assign issue    = (rd_idx_r != pull_len_r) && (!rd_vld_r || out_free);

  frq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_we),
    .wr_addr (byte_waddr),
    .wr_data (in_data.data_byte),
    .rd_en   (byte_re),
    .rd_addr (byte_raddr),
    .rd_data (byte_rdata)
  );

  frq_ram #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_FRAMES)
  ) u_desc_ram (
    .clk     (clk),
    .wr_en   (desc_we),
    .wr_addr (desc_waddr),
    .wr_data (desc_wdata),
    .rd_en   (desc_re),
    .rd_addr (tail_r),
    .rd_data (desc_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.opcode == OP_PULL && head_r != tail_r) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (d_reject || d_len == '0) begin
          if (out_free) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (rd_vld_r && rd_last_r && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    push_cnt_nxt  = push_cnt_r;
    push_over_nxt = push_over_r;
    pull_slot_nxt = pull_slot_r;
    pull_len_nxt  = pull_len_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = rd_vld_r;
    rd_last_nxt   = rd_last_r;
    byte_we       = 1'b0;
    byte_waddr    = byte_addr(head_r, push_cnt_r[IDX_W-1:0]);
    byte_re       = 1'b0;
    byte_raddr    = byte_addr(pull_slot_r, rd_idx_r[IDX_W-1:0]);
    desc_we       = 1'b0;
    desc_waddr    = head_r;
    desc_re       = 1'b0;
    cnt_upd       = push_cnt_r;
    over_upd      = push_over_r;
    desc_wdata    = {over_upd, cnt_upd};
    ld_en         = 1'b0;
    ld_byte       = '0;
    ld_present    = 1'b0;
    ld_last       = 1'b1;
    ld_status     = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.opcode == OP_PUSH) begin
          // store the byte while there is room, else flag the frame
          if (in_data.carries_byte) begin
            if (push_cnt_r < CNT_MAX) begin
              byte_we = 1'b1;
              cnt_upd = push_cnt_r + 1'b1;
            end else begin
              over_upd = 1'b1;
            end
          end
          push_cnt_nxt  = cnt_upd;
          push_over_nxt = over_upd;
          desc_wdata    = {over_upd, cnt_upd};
          if (in_data.frame_end) begin
            // commit; drop the oldest frame when the head runs into it
            desc_we       = 1'b1;
            head_nxt      = slot_inc(head_r);
            if (slot_inc(head_r) == tail_r) begin
              tail_nxt = slot_inc(tail_r);
            end
            push_cnt_nxt  = '0;
            push_over_nxt = 1'b0;
          end
          ld_en = 1'b1;
        end else if (accept) begin
          if (head_r == tail_r) begin
            ld_en     = 1'b1;
            ld_status = STAT_EMPTY;
          end else begin
            desc_re = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        pull_slot_nxt = tail_r;
        pull_len_nxt  = d_len;
        rd_idx_nxt    = '0;
        rd_vld_nxt    = 1'b0;
        if (d_reject) begin
          // hold the tail in place
          ld_en     = out_free;
          ld_status = STAT_LIMIT;
        end else if (d_len == '0) begin
          ld_en = out_free;
          if (out_free) begin
            tail_nxt = slot_inc(tail_r);
          end
        end else begin
          tail_nxt = slot_inc(tail_r);
        end
      end
      ST_EMIT: begin
        if (rd_vld_r && out_free) begin
          ld_en      = 1'b1;
          ld_byte    = byte_rdata;
          ld_present = 1'b1;
          ld_last    = rd_last_r;
          rd_vld_nxt = 1'b0;
        end
        if (issue) begin
          byte_re     = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (rd_idx_r + 1'b1 == pull_len_r);
        end
      end
      default: begin
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  // result word, flags taken from the pointers after this cycle's update
  always_comb begin
    held_diff = HW'(head_nxt) - HW'(tail_nxt);
    held_val  = (head_nxt < tail_nxt) ? held_diff + HW'(QUEUE_FRAMES) : held_diff;

    out_data_nxt              = out_data_r;
    out_valid_nxt             = out_valid_r && out_stall;
    if (ld_en) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_byte     = ld_byte;
      out_data_nxt.byte_present = ld_present;
      out_data_nxt.run_last     = ld_last;
      out_data_nxt.status       = ld_status;
      out_data_nxt.frames_held  = held_val[HELD_W-1:0];
      out_data_nxt.not_empty    = (head_nxt != tail_nxt);
      out_data_nxt.is_full      = (slot_inc(head_nxt) == tail_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      push_cnt_r  <= '0;
      push_over_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      push_cnt_r  <= push_cnt_nxt;
      push_over_r <= push_over_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    pull_slot_r <= pull_slot_nxt;
    pull_len_r  <= pull_len_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_last_r   <= rd_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
